### sv/dhoat_pkg.sv
// Shared constants and code types for the double-hashing key/value table.
`timescale 1ns / 1ps
`default_nettype none

package dhoat_pkg;

  // Default sizing, handed to the top level's parameters.
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Slot marks held per table slot.
  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_UPDATED   = 3'd1,
    STATUS_FOUND     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_REMOVED   = 3'd4,
    STATUS_FULL      = 3'd5
  } status_e;

endpackage

`default_nettype wire

### sv/dhoat_hash.sv
// Iterative unit that forms both probe hashes of a key, one key chunk per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dhoat_hash #(
  parameter int CAPACITY = dhoat_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = dhoat_pkg::DEF_KEY_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [KEY_BITS-1:0]         key_i,
  output logic                             done_o,
  output logic [$clog2(CAPACITY)-1:0]      h1_o,
  output logic [$clog2(CAPACITY)-1:0]      h2_o
);

  // CAPACITY is a power of two, so the key modulo CAPACITY is its low bits,
  // and 2^AW is one modulo CAPACITY - 1, so summing AW-bit chunks of the key
  // with end-around carry gives the key modulo CAPACITY - 1.
  localparam int AW  = $clog2(CAPACITY);
  localparam int NCH = (KEY_BITS + AW - 1) / AW;
  localparam int PW  = NCH * AW;
  localparam int NCW = $clog2(NCH + 1);

  logic           busy_q;
  logic           done_q;
  logic [NCW-1:0] cnt_q;
  logic [PW-1:0]  key_pad;
  logic [PW-1:0]  key_q;
  logic [AW-1:0]  h1_q;
  logic [AW-1:0]  acc_q, acc_d;
  logic [AW:0]    sum;

  assign key_pad = PW'(key_i);

  // One shared adder: add the next chunk and fold the carry back in. An
  // all-ones total stands for zero.
  always_comb begin
    sum   = {1'b0, acc_q} + {1'b0, key_q[AW-1:0]};
    acc_d = sum[AW-1:0] + AW'(sum[AW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_pad;
      h1_q  <= key_pad[AW-1:0];
      acc_q <= '0;
      cnt_q <= NCW'(NCH - 1);
    end else if (busy_q) begin
      key_q <= key_q >> AW;
      acc_q <= acc_d;
      cnt_q <= cnt_q - NCW'(1);
    end
  end

  assign done_o = done_q;
  assign h1_o   = h1_q;
  assign h2_o   = (acc_q == '1) ? AW'(1) : AW'(acc_q + AW'(1));

endmodule

`default_nettype wire

### sv/double_hash_open_address_table_top.sv
// Top level of the open-addressing key/value table with double hashing.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i / in_stall_o  op_i, key_i, value_i
//   output    out        out_valid_o / out_stall_i status_o, read_value_o, entry_count_o
//
// One operation passes through the transfer, the hash unit (NCH = KEY_BITS /
// log2(CAPACITY) rounded up, one key chunk per cycle), a walk of up to
// CAPACITY probes along the probe path through the single read port of the
// slot memories, and a write-back that also loads the result. An undefined
// op code skips hashing and probing. CAPACITY is a power of two.
// After reset a clearing pass marks every slot empty;
// the input is stalled until it is over.
// A new input transfer is taken while a finished result still waits in the
// output register; only the write-back waits for the output to be free.
`timescale 1ns / 1ps
`default_nettype none

module double_hash_open_address_table_top #(
  parameter int CAPACITY   = dhoat_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = dhoat_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = dhoat_pkg::DEF_VALUE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [KEY_BITS-1:0]           key_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [VALUE_BITS-1:0]              read_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count_o
);

  localparam int AW = $clog2(CAPACITY);      // slot index width
  localparam int CW = $clog2(CAPACITY + 1);  // probe and entry counters
  localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_HASH   = 5'b00100,
    S_PROBE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Operation held for the whole of its run.
  logic [1:0]            op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // Hash unit.
  logic          hash_start;
  logic          hash_done;
  logic [AW-1:0] h1, h2;

  // Probe walk.
  logic [AW-1:0] addr_q;
  logic [AW-1:0] h2_q;
  logic [CW-1:0] issue_cnt_q;
  logic          pend_q;
  logic [AW-1:0] rd_slot_q;
  logic [AW:0]   addr_sum;
  logic [AW-1:0] addr_next;
  logic          issue;

  // Slot memories and their registered read data.
  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] value_mem [CAPACITY];
  dhoat_pkg::mark_e      mark_mem  [CAPACITY];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_value_q;
  dhoat_pkg::mark_e      rd_mark_q;

  // Findings of the walk.
  logic                  hit_vld_q;
  logic [AW-1:0]         hit_slot_q;
  logic [VALUE_BITS-1:0] hit_value_q;
  logic                  free_vld_q;
  logic [AW-1:0]         free_slot_q;
  logic                  is_match, is_empty, is_free;

  // Write port shared by the clearing pass and the write-back.
  logic             key_we, value_we, mark_we;
  logic [AW-1:0]    wr_addr;
  dhoat_pkg::mark_e mark_wd;

  logic [AW-1:0] clr_q;
  logic [CW-1:0] count_q, count_d;

  // Result.
  logic                  out_free;
  logic                  finish_go;
  logic                  out_valid_q;
  logic [2:0]            status_q;
  logic [VALUE_BITS-1:0] read_value_q;
  logic [CW-1:0]         entry_count_q;
  dhoat_pkg::status_e    status_d;
  logic [VALUE_BITS-1:0] read_value_d;

  logic in_xfer;
  logic op_known;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign op_known   = (op_i == dhoat_pkg::OP_INSERT) || (op_i == dhoat_pkg::OP_FIND) ||
                      (op_i == dhoat_pkg::OP_REMOVE);
  assign hash_start = in_xfer && op_known;

  dhoat_hash #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .h1_o    (h1),
    .h2_o    (h2)
  );

  // Next probe address: one add and one conditional subtract of the capacity.
  always_comb begin
    addr_sum  = {1'b0, addr_q} + {1'b0, h2_q};
    addr_next = (addr_sum >= CAP_W) ? AW'(addr_sum - CAP_W) : addr_sum[AW-1:0];
  end

  assign issue = (state_q == S_PROBE) && (issue_cnt_q != CW'(CAPACITY));

  // Classification of the slot whose read data arrived this cycle.
  assign is_empty = pend_q && (rd_mark_q == dhoat_pkg::MARK_EMPTY);
  assign is_free  = pend_q && (rd_mark_q != dhoat_pkg::MARK_OCCUPIED);
  assign is_match = pend_q && (rd_mark_q == dhoat_pkg::MARK_OCCUPIED) && (rd_key_q == key_q);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish_go = (state_q == S_FINISH) && out_free;

  // Write-back decision, result and memory writes.
  always_comb begin
    status_d     = dhoat_pkg::STATUS_NOT_FOUND;
    read_value_d = '0;
    count_d      = count_q;
    key_we       = 1'b0;
    value_we     = 1'b0;
    mark_we      = 1'b0;
    wr_addr      = hit_slot_q;
    mark_wd      = dhoat_pkg::MARK_OCCUPIED;
    if (state_q == S_CLEAR) begin
      mark_we = 1'b1;
      wr_addr = clr_q;
      mark_wd = dhoat_pkg::MARK_EMPTY;
    end else if (finish_go) begin
      case (op_q)
        dhoat_pkg::OP_INSERT: begin
          if (hit_vld_q) begin
            value_we = 1'b1;
            status_d = dhoat_pkg::STATUS_UPDATED;
          end else if (free_vld_q) begin
            wr_addr  = free_slot_q;
            key_we   = 1'b1;
            value_we = 1'b1;
            mark_we  = 1'b1;
            count_d  = CW'(count_q + CW'(1));
            status_d = dhoat_pkg::STATUS_INSERTED;
          end else begin
            status_d = dhoat_pkg::STATUS_FULL;
          end
        end
        dhoat_pkg::OP_FIND: begin
          if (hit_vld_q) begin
            status_d     = dhoat_pkg::STATUS_FOUND;
            read_value_d = hit_value_q;
          end
        end
        dhoat_pkg::OP_REMOVE: begin
          if (hit_vld_q) begin
            mark_we  = 1'b1;
            mark_wd  = dhoat_pkg::MARK_DELETED;
            count_d  = CW'(count_q - CW'(1));
            status_d = dhoat_pkg::STATUS_REMOVED;
          end
        end
        default: begin
          status_d = dhoat_pkg::STATUS_NOT_FOUND;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(CAPACITY - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_d = op_known ? S_HASH : S_FINISH;
      end
      S_HASH: begin
        if (hash_done) state_d = S_PROBE;
      end
      S_PROBE: begin
        // Stop at a match, at an empty slot, or once every probe is checked.
        if (is_match || is_empty || (issue_cnt_q == CW'(CAPACITY))) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      hit_vld_q   <= 1'b0;
      free_vld_q  <= 1'b0;
      issue_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_CLEAR) clr_q <= AW'(clr_q + AW'(1));

      if (finish_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        hit_vld_q  <= 1'b0;
        free_vld_q <= 1'b0;
      end
      if (state_q == S_HASH && hash_done) begin
        issue_cnt_q <= '0;
        pend_q      <= 1'b0;
      end
      if (state_q == S_PROBE) begin
        pend_q <= issue;
        if (issue) issue_cnt_q <= CW'(issue_cnt_q + CW'(1));
        if (is_free && !free_vld_q) free_vld_q <= 1'b1;
        if (is_match) hit_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (state_q == S_HASH && hash_done) begin
      addr_q <= h1;
      h2_q   <= h2;
    end else if (issue) begin
      addr_q <= addr_next;
    end
    rd_slot_q <= addr_q;
    if (state_q == S_PROBE) begin
      if (is_free && !free_vld_q) free_slot_q <= rd_slot_q;
      if (is_match) begin
        hit_slot_q  <= rd_slot_q;
        hit_value_q <= rd_value_q;
      end
    end
    if (finish_go) begin
      status_q      <= status_d;
      read_value_q  <= read_value_d;
      entry_count_q <= count_d;
    end
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= key_q;
    rd_key_q <= key_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (value_we) value_mem[wr_addr] <= value_q;
    rd_value_q <= value_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    rd_mark_q <= mark_mem[addr_q];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

### sv/dhoat_checker.sv
// Port-level assertions for the double-hashing table, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module dhoat_checker #(
  parameter int CAPACITY   = dhoat_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = dhoat_pkg::DEF_VALUE_BITS
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [2:0]                    status_o,
  input wire logic [VALUE_BITS-1:0]         read_value_o,
  input wire logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(read_value_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // The block works on one operation at a time.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a transfer");

  // The occupied count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // Only a successful find returns a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dhoat_pkg::STATUS_FOUND) |-> read_value_o == '0)
    else $error("read value without a find hit");

  // A key that is stored leaves the table non-empty.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == dhoat_pkg::STATUS_INSERTED) ||
    (status_o == dhoat_pkg::STATUS_UPDATED) || (status_o == dhoat_pkg::STATUS_FOUND))
    |-> entry_count_o != '0)
    else $error("empty table reports a stored key");

endmodule

bind double_hash_open_address_table_top dhoat_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS)
) u_dhoat_checker (.*);

`default_nettype wire
